// ===== src/maze_carver_depth_first_top_assert.svh =====
// ----------------------------------------------------------------------------
// Maze carver assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MAZE_CARVER_DEPTH_FIRST_TOP_ASSERT_SVH
`define MAZE_CARVER_DEPTH_FIRST_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MCDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("maze carver assertion failed");

// Next-cycle implication, disabled during reset
`define MCDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("maze carver assertion failed");

`endif

// ===== src/mcdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Maze carver package
// Types, codes and helper functions shared by the maze carver files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcdf_pkg;

  localparam int MAX_SIDE = 64;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int ADDR_W   = 2 * COORD_W;
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int SIDE_W   = 7;
  localparam int RAND_W   = 15;

  localparam logic [SIDE_W-1:0] SIDE_MIN   = 7'd3;
  localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd16;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] EV_CARVED = 2'd0;
  localparam logic [1:0] EV_BACK   = 2'd1;
  localparam logic [1:0] EV_FINISH = 2'd2;
  localparam logic [1:0] EV_READ   = 2'd3;

  localparam logic [2:0] DIR_NONE    = 3'd0;
  localparam logic [2:0] DIR_ROW_INC = 3'd1;
  localparam logic [2:0] DIR_COL_INC = 3'd2;
  localparam logic [2:0] DIR_ROW_DEC = 3'd3;
  localparam logic [2:0] DIR_COL_DEC = 3'd4;

  localparam logic [3:0] OPEN_ROW_DEC = 4'd1;
  localparam logic [3:0] OPEN_COL_INC = 4'd2;
  localparam logic [3:0] OPEN_ROW_INC = 4'd4;
  localparam logic [3:0] OPEN_COL_DEC = 4'd8;

  typedef struct packed {
    logic [1:0]         op;
    logic [RAND_W-1:0]  rand_value;
    logic [COORD_W-1:0] read_row;
    logic [COORD_W-1:0] read_col;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic [2:0]         move_dir;
    logic [3:0]         openings;
    logic               done_res;
  } out_rsp_t;

  typedef struct packed {
    logic [2:0] parent;
    logic       visited;
    logic [3:0] openings;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  function automatic logic [3:0] bit_here(input logic [2:0] dir);
    logic [3:0] b;
    case (dir)
      DIR_ROW_INC: b = OPEN_ROW_INC;
      DIR_COL_INC: b = OPEN_COL_INC;
      DIR_ROW_DEC: b = OPEN_ROW_DEC;
      DIR_COL_DEC: b = OPEN_COL_DEC;
      default:     b = 4'd0;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] bit_there(input logic [2:0] dir);
    logic [3:0] b;
    case (dir)
      DIR_ROW_INC: b = OPEN_ROW_DEC;
      DIR_COL_INC: b = OPEN_COL_DEC;
      DIR_ROW_DEC: b = OPEN_ROW_INC;
      DIR_COL_DEC: b = OPEN_COL_INC;
      default:     b = 4'd0;
    endcase
    return b;
  endfunction

  // 4 is 1 mod 3: sum the base-4 digits, then fold
  function automatic logic [1:0] mod3(input logic [RAND_W-1:0] v);
    logic [RAND_W:0] w;
    logic [4:0]      s;
    logic [2:0]      t;
    w = {1'b0, v};
    s = '0;
    for (int i = 0; i < (RAND_W + 1) / 2; i++) begin
      s = s + 5'(w[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

// ===== src/mcdf_ram.sv =====
// ----------------------------------------------------------------------------
// Maze carver cell RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcdf_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/maze_carver_depth_first_top.sv =====
// ----------------------------------------------------------------------------
// Maze carver, depth-first
// Carves a maze one step per request into a 64x64 cell RAM.
// ----------------------------------------------------------------------------
// All cell state (openings, visited bit, parent direction) lives in one
// 4096-entry RAM with a registered read. A step or read request goes
// through these steps from its acceptance to the next acceptance:
// - five RAM reads (the current cell, then its four neighbours) over the
//   single read port, then a wait for the last read data
// - a decision step
// - one RAM write per carved cell
// - handing the result to the output register, once it is free or being taken
// - the idle state that takes the next request
// A start request sweeps the whole RAM, one cell per cycle. Its result is
// handed out when the sweep ends, and the next request is taken after it.
// After reset the same clearing pass runs with in_ready_o low. grid_size
// writes are taken at any time. The result waits in an output register, so
// the next request is accepted while it is still not taken. A second result
// waits until the first is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module maze_carver_depth_first_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mcdf_pkg::SIDE_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  mcdf_pkg::in_req_t           in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mcdf_pkg::out_rsp_t          out_rsp_o
);

  import mcdf_pkg::*;

  localparam logic [2:0] ST_SWEEP    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_FETCH    = 3'd2;
  localparam logic [2:0] ST_DECIDE   = 3'd3;
  localparam logic [2:0] ST_WR_THERE = 3'd4;
  localparam logic [2:0] ST_EMIT     = 3'd5;

  localparam logic [2:0] FETCH_LAST = 3'd5;
  localparam logic [2:0] FETCH_READS = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [SIDE_W-1:0]  grid_q;
  logic [SIDE_W-1:0]  sweep_side_q;
  logic [ADDR_W-1:0]  sweep_q;
  logic               sweep_emit_q;
  logic [2:0]         fetch_q;
  logic [1:0]         op_q;
  logic [COORD_W-1:0] cur_row_q, cur_col_q;
  logic               walk_done_q;
  logic               out_valid_q;

  logic [1:0]         rmod4_q, rmod3_q;
  logic [ADDR_W-1:0]  rd_addr_q;
  cell_t              word_q [5];
  out_rsp_t           res_q;
  out_rsp_t           out_q;
  logic [ADDR_W-1:0]  there_addr_q;
  cell_t              there_word_q;

  logic               accept;
  logic               emit_go;
  logic               sweep_last;
  logic [SIDE_W-1:0]  side_now;
  logic [SIDE_W-1:0]  lim;
  logic [SIDE_W-1:0]  nb_r [4];
  logic [SIDE_W-1:0]  nb_c [4];
  logic [ADDR_W-1:0]  nb_addr [4];
  logic [3:0]         cand;
  logic [2:0]         cand_n;
  logic [1:0]         pick_idx;
  logic [1:0]         pick;
  logic [2:0]         pick_dir;
  logic               do_carve;
  logic [2:0]         par;
  logic [2:0]         back_dir;
  logic [2:0]         back_sel;
  logic               back_ok;
  logic               at_root;
  logic [3:0]         here_open;
  logic [2:0]         fetch_m1;
  logic [ADDR_W-1:0]  here_addr;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  cell_t              ram_wdata, ram_rdata;

  logic [SIDE_W-1:0]  sw_r, sw_c;
  logic               sw_border;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign emit_go     = !out_valid_q || out_ready_i;
  assign sweep_last  = &sweep_q;
  assign here_addr   = {cur_row_q, cur_col_q};
  assign here_open   = word_q[0].openings;
  assign fetch_m1    = fetch_q - 3'd1;

  always_comb begin
    if (grid_q < SIDE_MIN) begin
      side_now = SIDE_MIN;
    end else if (grid_q > SIDE_MAX) begin
      side_now = SIDE_MAX;
    end else begin
      side_now = grid_q;
    end
  end

  assign lim = side_now - 7'd2;

  // Neighbour order: col-1, row-1, col+1, row+1
  always_comb begin
    nb_r[0] = {1'b0, cur_row_q};
    nb_c[0] = {1'b0, cur_col_q} - 7'd1;
    nb_r[1] = {1'b0, cur_row_q} - 7'd1;
    nb_c[1] = {1'b0, cur_col_q};
    nb_r[2] = {1'b0, cur_row_q};
    nb_c[2] = {1'b0, cur_col_q} + 7'd1;
    nb_r[3] = {1'b0, cur_row_q} + 7'd1;
    nb_c[3] = {1'b0, cur_col_q};
    for (int j = 0; j < 4; j++) begin
      nb_addr[j] = {nb_r[j][COORD_W-1:0], nb_c[j][COORD_W-1:0]};
      cand[j] = (nb_r[j] >= 7'd1) && (nb_r[j] <= lim) &&
                (nb_c[j] >= 7'd1) && (nb_c[j] <= lim) && !word_q[j+1].visited;
    end
  end

  assign cand_n = 3'($countones(cand));

  always_comb begin
    case (cand_n)
      3'd4:    pick_idx = rmod4_q;
      3'd3:    pick_idx = rmod3_q;
      3'd2:    pick_idx = {1'b0, rmod4_q[0]};
      default: pick_idx = 2'd0;
    endcase
  end

  always_comb begin
    logic [2:0] seen;
    logic       found;
    seen  = '0;
    found = 1'b0;
    pick  = 2'd0;
    for (int j = 0; j < 4; j++) begin
      if (cand[j] && !found && (seen == {1'b0, pick_idx})) begin
        pick  = 2'(j);
        found = 1'b1;
      end
      seen = seen + 3'(cand[j]);
    end
  end

  assign pick_dir = DIR_COL_DEC - {1'b0, pick};
  assign do_carve = (op_q == OP_STEP) && !walk_done_q && (cand_n != 3'd0);

  assign par      = word_q[0].parent;
  assign back_dir = ((par + 3'd1) & 3'd3) + 3'd1;
  assign back_sel = DIR_COL_DEC - back_dir;
  assign at_root  = (cur_row_q == COORD_W'(1)) && (cur_col_q == COORD_W'(1));

  always_comb begin
    case (back_dir)
      DIR_ROW_INC: back_ok = !(&cur_row_q);
      DIR_COL_INC: back_ok = !(&cur_col_q);
      DIR_ROW_DEC: back_ok = (cur_row_q != '0);
      DIR_COL_DEC: back_ok = (cur_col_q != '0);
      default:     back_ok = 1'b0;
    endcase
    back_ok = back_ok && !at_root && (par >= DIR_ROW_INC) && (par <= DIR_COL_DEC);
  end

  assign sw_r = {1'b0, sweep_q[ADDR_W-1:COORD_W]};
  assign sw_c = {1'b0, sweep_q[COORD_W-1:0]};
  assign sw_border = ((sw_r < sweep_side_q) && (sw_c < sweep_side_q) &&
                      ((sw_r == '0) || (sw_r == sweep_side_q - 7'd1) ||
                       (sw_c == '0) || (sw_c == sweep_side_q - 7'd1))) ||
                     ((sw_r == 7'd1) && (sw_c == 7'd1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_q;
    ram_wdata = '0;
    case (state_q)
      ST_SWEEP: begin
        ram_we            = 1'b1;
        ram_wdata.visited = sw_border;
      end
      ST_DECIDE: begin
        ram_we             = do_carve;
        ram_waddr          = here_addr;
        ram_wdata          = word_q[0];
        ram_wdata.openings = here_open | bit_here(pick_dir);
      end
      ST_WR_THERE: begin
        ram_we    = 1'b1;
        ram_waddr = there_addr_q;
        ram_wdata = there_word_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign ram_re = (state_q == ST_FETCH) && (fetch_q <= FETCH_READS);

  always_comb begin
    if (fetch_q == '0) begin
      ram_raddr = (op_q == OP_READ) ? rd_addr_q : here_addr;
    end else begin
      ram_raddr = nb_addr[fetch_m1[1:0]];
    end
  end

  mcdf_ram #(
    .DEPTH (CELLS),
    .WIDTH (CELL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (sweep_last) begin
          state_d = sweep_emit_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_req_i.op)
            OP_START: state_d = ST_SWEEP;
            OP_STEP:  state_d = ST_FETCH;
            OP_READ:  state_d = ST_FETCH;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_FETCH: begin
        if (fetch_q == FETCH_LAST) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE:   state_d = do_carve ? ST_WR_THERE : ST_EMIT;
      ST_WR_THERE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      grid_q       <= SIDE_RESET;
      sweep_side_q <= SIDE_RESET;
      sweep_q      <= '0;
      sweep_emit_q <= 1'b0;
      fetch_q      <= '0;
      op_q         <= OP_NONE;
      cur_row_q    <= COORD_W'(1);
      cur_col_q    <= COORD_W'(1);
      walk_done_q  <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        grid_q <= cfg_wdata_i;
      end
      if (state_q == ST_SWEEP) begin
        sweep_q <= sweep_q + ADDR_W'(1);
        if (sweep_last) begin
          sweep_emit_q <= 1'b0;
          if (sweep_emit_q) begin
            cur_row_q   <= COORD_W'(1);
            cur_col_q   <= COORD_W'(1);
            walk_done_q <= 1'b0;
          end
        end
      end
      if (accept) begin
        op_q    <= in_req_i.op;
        fetch_q <= '0;
        if (in_req_i.op == OP_START) begin
          sweep_side_q <= side_now;
          sweep_q      <= '0;
          sweep_emit_q <= 1'b1;
        end
      end
      if (state_q == ST_FETCH) begin
        fetch_q <= fetch_q + 3'd1;
      end
      if ((state_q == ST_DECIDE) && (op_q == OP_STEP) && !walk_done_q) begin
        if (do_carve) begin
          cur_row_q <= nb_r[pick][COORD_W-1:0];
          cur_col_q <= nb_c[pick][COORD_W-1:0];
        end else if (back_ok) begin
          cur_row_q <= nb_r[back_sel[1:0]][COORD_W-1:0];
          cur_col_q <= nb_c[back_sel[1:0]][COORD_W-1:0];
        end else begin
          walk_done_q <= 1'b1;
        end
      end
      if ((state_q == ST_EMIT) && emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rmod4_q   <= in_req_i.rand_value[1:0];
      rmod3_q   <= mod3(in_req_i.rand_value);
      rd_addr_q <= {in_req_i.read_row, in_req_i.read_col};
    end
    if ((state_q == ST_FETCH) && (fetch_q != '0)) begin
      word_q[4] <= ram_rdata;
      for (int i = 0; i < 4; i++) begin
        word_q[i] <= word_q[i+1];
      end
    end
    if ((state_q == ST_SWEEP) && sweep_last) begin
      res_q.event_res <= EV_FINISH;
      res_q.cell_row  <= COORD_W'(1);
      res_q.cell_col  <= COORD_W'(1);
      res_q.move_dir  <= DIR_NONE;
      res_q.openings  <= '0;
      res_q.done_res  <= 1'b0;
    end
    if (state_q == ST_DECIDE) begin
      res_q.cell_row <= cur_row_q;
      res_q.cell_col <= cur_col_q;
      res_q.move_dir <= DIR_NONE;
      res_q.openings <= here_open;
      res_q.done_res <= 1'b1;
      if (op_q == OP_READ) begin
        res_q.event_res <= EV_READ;
        res_q.cell_row  <= rd_addr_q[ADDR_W-1:COORD_W];
        res_q.cell_col  <= rd_addr_q[COORD_W-1:0];
        res_q.done_res  <= walk_done_q;
      end else if (walk_done_q) begin
        res_q.event_res <= EV_FINISH;
      end else if (do_carve) begin
        res_q.event_res <= EV_CARVED;
        res_q.move_dir  <= pick_dir;
        res_q.openings  <= here_open | bit_here(pick_dir);
        res_q.done_res  <= 1'b0;
      end else if (back_ok) begin
        res_q.event_res <= EV_BACK;
        res_q.move_dir  <= back_dir;
        res_q.done_res  <= 1'b0;
      end else begin
        res_q.event_res <= EV_FINISH;
      end
      there_addr_q          <= nb_addr[pick];
      there_word_q.parent   <= pick_dir;
      there_word_q.visited  <= 1'b1;
      there_word_q.openings <= word_q[pick + 3'd1].openings | bit_there(pick_dir);
    end
    if ((state_q == ST_EMIT) && emit_go) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== src/mcdf_checker.sv =====
// ----------------------------------------------------------------------------
// Maze carver port checker
// Port-level properties of the maze carver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "maze_carver_depth_first_top_assert.svh"

module mcdf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input mcdf_pkg::in_req_t           in_req_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input mcdf_pkg::out_rsp_t          out_rsp_o
);

  import mcdf_pkg::*;

  logic stalled;
  logic is_carve;
  logic is_read;
  logic start_acc;

  assign stalled   = out_valid_o && !out_ready_i;
  assign is_carve  = out_valid_o && (out_rsp_o.event_res == EV_CARVED);
  assign is_read   = out_valid_o && (out_rsp_o.event_res == EV_READ);
  assign start_acc = in_valid_i && in_ready_o && (in_req_i.op == OP_START) && !cfg_we_i;

  `MCDF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_o && $stable(out_rsp_o))
  `MCDF_ASSERT_IMP(a_carve_moves, clk_i, rst_ni, is_carve,
                   (out_rsp_o.done_res == 1'b0) && (out_rsp_o.move_dir != DIR_NONE) &&
                   (out_rsp_o.move_dir <= DIR_COL_DEC) && (out_rsp_o.openings != 4'd0))
  `MCDF_ASSERT_IMP(a_read_no_move, clk_i, rst_ni, is_read, out_rsp_o.move_dir == DIR_NONE)
  `MCDF_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start_acc, !in_ready_o)

endmodule

bind maze_carver_depth_first_top mcdf_checker u_mcdf_checker (.*);
